// File: sv/byte_ring_buffer_burst_unit_macros.svh
// ----------------------------------------------------------------------------
// Byte ring buffer burst unit: assertion macros
// Shared concurrent assertion forms, clocked on clk, idle while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BYTE_RING_BUFFER_BURST_UNIT_MACROS_SVH
`define BYTE_RING_BUFFER_BURST_UNIT_MACROS_SVH

// Same-cycle implication.
`define BRBB_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("brbb: same-cycle check failed");

// Next-cycle implication.
`define BRBB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("brbb: next-cycle check failed");

`endif

// File: sv/brbb_pkg.sv
// ----------------------------------------------------------------------------
// Byte ring buffer burst package
// Sizes, request and result records, and the byte store access record.
// ----------------------------------------------------------------------------
package brbb_pkg;

    localparam int DEPTH     = 4096;
    localparam int MAX_BURST = 64;
    localparam int PTR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int LEN_W     = 7;
    localparam int BYTE_W    = 8;

    typedef struct packed {
        logic              action;
        logic              first;
        logic [LEN_W-1:0]  length;
        logic [BYTE_W-1:0] data_in;
    } in_t;

    typedef struct packed {
        logic              status;
        logic [BYTE_W-1:0] data_out;
        logic              is_read;
        logic              last;
    } out_t;

    typedef struct packed {
        logic              we;
        logic [PTR_W-1:0]  waddr;
        logic [BYTE_W-1:0] wdata;
        logic              re;
        logic [PTR_W-1:0]  raddr;
    } mem_req_t;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    localparam logic ST_OK     = 1'b0;
    localparam logic ST_REJECT = 1'b1;

endpackage

// File: sv/brbb_store.sv
// ----------------------------------------------------------------------------
// Byte ring buffer byte store
// Single-write, single-read synchronous byte memory with registered read data.
// ----------------------------------------------------------------------------
module brbb_store (
    input  logic                     clk,
    input  brbb_pkg::mem_req_t       req,
    output logic [brbb_pkg::BYTE_W-1:0] rdata
);
    import brbb_pkg::*;

    logic [BYTE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata <= mem[req.raddr];
        end
    end

endmodule

// File: sv/byte_ring_buffer_burst_unit.sv
// ----------------------------------------------------------------------------
// Byte ring buffer burst unit
// Circular byte buffer with a fill count, all-or-nothing write bursts and
// all-or-nothing read requests.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Write bytes are taken
// one per cycle while busy is low; the status of a first byte shows in the
// cycle after the request. A read request that fails shows its status in the
// cycle after the request. A read of N bytes holds busy until its last byte is
// read from the store and returns one byte per cycle starting the cycle after
// the request; no new request is taken until that last read. result_valid
// marks each result for exactly one cycle and cannot be held off. The store
// needs no clearing after reset.
// ----------------------------------------------------------------------------
`include "byte_ring_buffer_burst_unit_macros.svh"

module byte_ring_buffer_burst_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  brbb_pkg::in_t  cmd,
    output logic           result_valid,
    output brbb_pkg::out_t result
);
    import brbb_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_READ
    } state_t;

    state_t            state_reg,      state_next;
    logic [PTR_W-1:0]  wr_ptr_reg,     wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg,     rd_ptr_next;
    logic [CNT_W-1:0]  fill_reg,       fill_next;
    logic [LEN_W-1:0]  burst_rem_reg,  burst_rem_next;
    logic              burst_drop_reg, burst_drop_next;
    logic [LEN_W-1:0]  cnt_reg,        cnt_next;
    logic              stat_valid_reg, stat_valid_next;
    out_t              stat_reg,       stat_next;
    logic              rd_pend_reg,    rd_pend_next;
    logic              rd_last_reg,    rd_last_next;

    mem_req_t          mem_req;
    logic [BYTE_W-1:0] mem_rdata;

    logic              accept;
    logic              len_ok;
    logic              space_ok;
    logic              data_ok;
    logic [CNT_W-1:0]  free_cnt;
    logic              do_store;
    logic              do_read;
    logic              read_last;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    brbb_store u_store (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    assign busy     = (state_reg == S_READ);
    assign accept   = start && !busy;
    assign len_ok   = (cmd.length != '0) && (cmd.length <= LEN_W'(MAX_BURST));
    assign free_cnt = CNT_W'(DEPTH) - fill_reg;
    assign space_ok = {{CNT_W{1'b0}}, cmd.length} <= {{LEN_W{1'b0}}, free_cnt};
    assign data_ok  = {{CNT_W{1'b0}}, cmd.length} <= {{LEN_W{1'b0}}, fill_reg};

    always_comb
    begin
        state_next      = state_reg;
        wr_ptr_next     = wr_ptr_reg;
        rd_ptr_next     = rd_ptr_reg;
        fill_next       = fill_reg;
        burst_rem_next  = burst_rem_reg;
        burst_drop_next = burst_drop_reg;
        cnt_next        = cnt_reg;
        stat_valid_next = 1'b0;
        stat_next       = stat_reg;
        rd_pend_next    = 1'b0;
        rd_last_next    = 1'b0;
        do_store        = 1'b0;
        do_read         = 1'b0;
        read_last       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && cmd.action == ACT_WRITE)
                begin
                    if (cmd.first)
                    begin
                        stat_valid_next = 1'b1;
                        stat_next       = '{status: ST_REJECT, data_out: '0,
                                            is_read: 1'b0, last: 1'b1};
                        if (!len_ok)
                        begin
                            burst_rem_next  = '0;
                            burst_drop_next = 1'b0;
                        end
                        else if (!space_ok)
                        begin
                            burst_rem_next  = cmd.length - 1'b1;
                            burst_drop_next = (cmd.length != LEN_W'(1));
                        end
                        else
                        begin
                            do_store         = 1'b1;
                            burst_rem_next   = cmd.length - 1'b1;
                            burst_drop_next  = 1'b0;
                            stat_next.status = ST_OK;
                        end
                    end
                    else if (burst_rem_reg != '0)
                    begin
                        burst_rem_next = burst_rem_reg - 1'b1;
                        do_store       = !burst_drop_reg;
                        if (burst_rem_reg == LEN_W'(1))
                        begin
                            burst_drop_next = 1'b0;
                        end
                    end
                end
                else if (accept && cmd.action == ACT_READ)
                begin
                    if (!len_ok || !data_ok)
                    begin
                        stat_valid_next = 1'b1;
                        stat_next       = '{status: ST_REJECT, data_out: '0,
                                            is_read: 1'b1, last: 1'b1};
                    end
                    else
                    begin
                        do_read   = 1'b1;
                        read_last = (cmd.length == LEN_W'(1));
                        cnt_next  = cmd.length - 1'b1;
                        if (cmd.length != LEN_W'(1))
                        begin
                            state_next = S_READ;
                        end
                    end
                end
            end
            S_READ:
            begin
                do_read   = 1'b1;
                read_last = (cnt_reg == LEN_W'(1));
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == LEN_W'(1))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        mem_req = '{we: 1'b0, waddr: wr_ptr_reg, wdata: cmd.data_in,
                    re: 1'b0, raddr: rd_ptr_reg};

        if (do_store && fill_reg != CNT_W'(DEPTH))
        begin
            mem_req.we  = 1'b1;
            wr_ptr_next = ptr_inc(wr_ptr_reg);
            fill_next   = fill_reg + 1'b1;
        end

        if (do_read)
        begin
            mem_req.re   = 1'b1;
            rd_ptr_next  = ptr_inc(rd_ptr_reg);
            fill_next    = fill_reg - 1'b1;
            rd_pend_next = 1'b1;
            rd_last_next = read_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            fill_reg       <= '0;
            burst_rem_reg  <= '0;
            burst_drop_reg <= 1'b0;
            cnt_reg        <= '0;
            stat_valid_reg <= 1'b0;
            stat_reg       <= '0;
            rd_pend_reg    <= 1'b0;
            rd_last_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            fill_reg       <= fill_next;
            burst_rem_reg  <= burst_rem_next;
            burst_drop_reg <= burst_drop_next;
            cnt_reg        <= cnt_next;
            stat_valid_reg <= stat_valid_next;
            stat_reg       <= stat_next;
            rd_pend_reg    <= rd_pend_next;
            rd_last_reg    <= rd_last_next;
        end
    end

    assign result_valid = rd_pend_reg || stat_valid_reg;

    always_comb
    begin
        if (rd_pend_reg)
        begin
            result = '{status: ST_OK, data_out: mem_rdata, is_read: 1'b1,
                       last: rd_last_reg};
        end
        else
        begin
            result = stat_reg;
        end
    end

    `BRBB_ASSERT_SAME(a_one_source, stat_valid_reg, !rd_pend_reg)
    `BRBB_ASSERT_SAME(a_fill_bound, 1'b1, fill_reg <= CNT_W'(DEPTH))
    `BRBB_ASSERT_NEXT(a_busy_gives_byte, busy, rd_pend_reg)
    `BRBB_ASSERT_SAME(a_busy_count, busy, cnt_reg != '0 && !stat_valid_reg)

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte ring buffer burst unit testbench
// Sends write bursts, read requests and malformed requests to the unit and
// predicts every reply from a behavioral copy of the ring. The run covers
// illegal lengths, stray bytes, bursts cut short by a new first byte and reads
// in the middle of a burst. Replies are checked field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;

    import brbb_pkg::*;

    localparam int IDLE_LIMIT = 1000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        in_t        req;
        logic [4:0] gap;
    } queued_req_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    in_t  cmd = '0;
    logic busy;
    logic result_valid;
    out_t result;

    byte_ring_buffer_burst_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result       (result)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    queued_req_t queued_requests[$];
    out_t        due_replies[$];
    queued_req_t staged;
    logic        staged_valid = 1'b0;
    logic        took = 1'b0;
    int          errors = 0;
    int          issued = 0;
    logic        gapless = 1'b0;
    int          idle_cycles = 0;

    logic [BYTE_W-1:0] ring_mem [DEPTH];
    logic [PTR_W-1:0]  wr_at = '0;
    logic [PTR_W-1:0]  rd_at = '0;
    int                stored = 0;
    int                burst_left = 0;
    logic              dropping = 1'b0;

    function automatic logic [PTR_W-1:0] ring_next(logic [PTR_W-1:0] p);
        return (int'(p) == DEPTH - 1) ? '0 : p + 1'b1;
    endfunction

    task automatic keep_byte(logic [BYTE_W-1:0] b);
        if (stored < DEPTH)
        begin
            ring_mem[wr_at] = b;
            wr_at = ring_next(wr_at);
            stored++;
        end
    endtask

    task automatic predict_replies(in_t req);
        out_t r;
        int   len;
        logic len_ok;
        len = int'(req.length);
        len_ok = (len >= 1) && (len <= MAX_BURST);
        r = '0;
        r.last = 1'b1;
        if (req.action == ACT_WRITE)
        begin
            if (req.first)
            begin
                r.is_read = 1'b0;
                if (!len_ok)
                begin
                    burst_left = 0;
                    dropping = 1'b0;
                    r.status = ST_REJECT;
                end
                else if (len > DEPTH - stored)
                begin
                    burst_left = len - 1;
                    dropping = (burst_left != 0);
                    r.status = ST_REJECT;
                end
                else
                begin
                    keep_byte(req.data_in);
                    burst_left = len - 1;
                    dropping = 1'b0;
                    r.status = ST_OK;
                end
                due_replies.push_back(r);
            end
            else if (burst_left != 0)
            begin
                burst_left--;
                if (!dropping)
                    keep_byte(req.data_in);
                if (burst_left == 0)
                    dropping = 1'b0;
            end
        end
        else if (!len_ok || len > stored)
        begin
            r.status = ST_REJECT;
            r.is_read = 1'b1;
            due_replies.push_back(r);
        end
        else
        begin
            for (int i = 0; i < len; i++)
            begin
                r.status = ST_OK;
                r.is_read = 1'b1;
                r.data_out = ring_mem[rd_at];
                r.last = (i == len - 1);
                rd_at = ring_next(rd_at);
                stored--;
                due_replies.push_back(r);
            end
        end
    endtask

    task automatic check_field(string fname, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, fname, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        out_t want;
        if (!rst_n)
            took <= 1'b0;
        else
        begin
            took <= start && !busy;
            if (result_valid)
            begin
                if (due_replies.size() == 0)
                begin
                    $display("%0t: unexpected reply, expected none, got %h", $time, result);
                    errors++;
                end
                else
                begin
                    want = due_replies.pop_front();
                    check_field("status", 8'(want.status), 8'(result.status));
                    check_field("data_out", want.data_out, result.data_out);
                    check_field("is_read", 8'(want.is_read), 8'(result.is_read));
                    check_field("last", 8'(want.last), 8'(result.last));
                end
            end
            if (start && !busy)
                predict_replies(cmd);
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && (!start || took))
        begin
            if (!staged_valid && queued_requests.size() != 0)
            begin
                staged = queued_requests.pop_front();
                staged_valid = 1'b1;
            end
            if (staged_valid && staged.gap == 0)
            begin
                cmd <= staged.req;
                start <= 1'b1;
                staged_valid = 1'b0;
            end
            else
            begin
                start <= 1'b0;
                if (staged_valid)
                    staged.gap = staged.gap - 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || result_valid)
                idle_cycles <= 0;
            else if (idle_cycles + 1 >= IDLE_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic push_req(logic act, logic fst, int len, int data);
        queued_req_t q;
        if ($urandom_range(0, 19) == 0)
            gapless = !gapless;
        q.req.action = act;
        q.req.first = fst;
        q.req.length = LEN_W'(len);
        q.req.data_in = BYTE_W'(data);
        q.gap = gapless ? 5'd0 : 5'($urandom_range(0, 17));
        queued_requests.push_back(q);
        issued++;
    endtask

    task automatic push_burst(int len, int sent);
        push_req(ACT_WRITE, 1'b1, len, $urandom_range(0, 255));
        for (int i = 1; i < sent; i++)
            push_req(ACT_WRITE, 1'b0, $urandom_range(0, 127), $urandom_range(0, 255));
    endtask

    function automatic int pick_len();
        return ($urandom_range(0, 7) == 0) ? $urandom_range(1, MAX_BURST)
                                            : $urandom_range(1, 8);
    endfunction

    initial
    begin
        int pick;
        int len;
        int cut;

        // directed requests
        push_req(ACT_READ, 1'b0, 1, 'h00);
        push_req(ACT_WRITE, 1'b1, 0, 'hFF);
        push_req(ACT_WRITE, 1'b1, 127, 'h00);
        push_req(ACT_WRITE, 1'b1, MAX_BURST + 1, 'hA5);
        push_req(ACT_WRITE, 1'b0, 127, 'hFF);
        push_req(ACT_WRITE, 1'b1, 3, 'h00);
        push_req(ACT_WRITE, 1'b0, 0, 'hFF);
        push_req(ACT_WRITE, 1'b0, 127, 'h5A);
        push_req(ACT_READ, 1'b1, 0, 'hFF);
        push_req(ACT_READ, 1'b0, 127, 'h00);
        push_req(ACT_READ, 1'b1, 4, 'h00);
        push_req(ACT_READ, 1'b0, 3, 'h00);
        push_req(ACT_WRITE, 1'b1, 4, 'h11);
        push_req(ACT_WRITE, 1'b0, 4, 'h22);
        push_req(ACT_WRITE, 1'b1, 2, 'h33);
        push_req(ACT_WRITE, 1'b0, 2, 'h44);
        push_req(ACT_READ, 1'b0, 1, 'h00);
        push_req(ACT_WRITE, 1'b1, 3, 'h55);
        push_req(ACT_WRITE, 1'b0, 3, 'h66);
        push_req(ACT_READ, 1'b1, 3, 'hFF);
        push_req(ACT_WRITE, 1'b0, 3, 'h77);
        push_req(ACT_READ, 1'b0, 3, 'h00);

        // random traffic, mostly well-formed bursts and reads
        while (issued < 160)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                len = pick_len();
                push_burst(len, len);
            end
            else if (pick < 75)
                push_req(ACT_READ, 1'($urandom_range(0, 1)), pick_len(),
                         $urandom_range(0, 255));
            else if (pick < 82)
            begin
                len = $urandom_range(2, 16);
                push_burst(len, $urandom_range(1, len - 1));
            end
            else if (pick < 88)
            begin
                len = $urandom_range(2, 12);
                cut = $urandom_range(1, len - 1);
                push_burst(len, cut);
                push_req(ACT_READ, 1'($urandom_range(0, 1)), pick_len(),
                         $urandom_range(0, 255));
                for (int i = cut; i < len; i++)
                    push_req(ACT_WRITE, 1'b0, $urandom_range(0, 127), $urandom_range(0, 255));
            end
            else if (pick < 93)
                push_req(ACT_WRITE, 1'b0, $urandom_range(0, 127), $urandom_range(0, 255));
            else
                push_req(1'($urandom_range(0, 1)), 1'b1,
                         $urandom_range(0, 1) ? 0 : $urandom_range(MAX_BURST + 1, 127),
                         $urandom_range(0, 255));
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (queued_requests.size() != 0 || staged_valid || start)
            @(posedge clk);
        while (due_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
